FILE: sv/gdbm_pkg.sv
// ---------------------------------------------------------------------------
// gdbm_pkg: shared types and constants of the grid distortion map
// Holds register indexes, operation codes, the sequencer states and the
// request and response structs of the shared multiplier.
// ---------------------------------------------------------------------------
`default_nettype none
package gdbm_pkg;

  localparam logic [2:0] CFG_COEF_XX = 3'd0;
  localparam logic [2:0] CFG_COEF_XY = 3'd1;
  localparam logic [2:0] CFG_SHIFT_X = 3'd2;
  localparam logic [2:0] CFG_COEF_YX = 3'd3;
  localparam logic [2:0] CFG_COEF_YY = 3'd4;
  localparam logic [2:0] CFG_SHIFT_Y = 3'd5;
  localparam logic [2:0] CFG_GRID_W  = 3'd6;
  localparam logic [2:0] CFG_GRID_H  = 3'd7;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_APPLY = 1'b1;

  // Multiply operations, issued in this order.
  localparam logic [3:0] OP_XX   = 4'd0;
  localparam logic [3:0] OP_XY   = 4'd1;
  localparam logic [3:0] OP_YX   = 4'd2;
  localparam logic [3:0] OP_YY   = 4'd3;
  localparam logic [3:0] OP_XHYH = 4'd4;
  localparam logic [3:0] OP_X01  = 4'd5;
  localparam logic [3:0] OP_X10  = 4'd6;
  localparam logic [3:0] OP_XC   = 4'd7;
  localparam logic [3:0] OP_Y01  = 4'd8;
  localparam logic [3:0] OP_Y10  = 4'd9;
  localparam logic [3:0] OP_YC   = 4'd10;
  localparam int         NUM_OPS = 11;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_MISS  = 10'b0000000010,
    ST_MWAIT = 10'b0000000100,
    ST_PIX   = 10'b0000001000,
    ST_IDX   = 10'b0000010000,
    ST_RD    = 10'b0000100000,
    ST_RDL   = 10'b0001000000,
    ST_DIFF  = 10'b0010000000,
    ST_SUM   = 10'b0100000000,
    ST_FIN   = 10'b1000000000
  } gdbm_state_e;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } gdbm_mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [61:0] result;
  } gdbm_mul_rsp_t;

endpackage
`default_nettype wire

FILE: sv/gdbm_in_if.sv
// ---------------------------------------------------------------------------
// gdbm_in_if: input item channel
// Carries load and apply transactions with a valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none
interface gdbm_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic [5:0]         grid_col;
  logic [5:0]         grid_row;
  logic signed [31:0] load_offset_x;
  logic signed [31:0] load_offset_y;

  modport source (output valid, mode, coord_x, coord_y, grid_col, grid_row,
                  load_offset_x, load_offset_y, input ready);
  modport sink (input valid, mode, coord_x, coord_y, grid_col, grid_row,
                load_offset_x, load_offset_y, output ready);
endinterface
`default_nettype wire

FILE: sv/gdbm_out_if.sv
// ---------------------------------------------------------------------------
// gdbm_out_if: result channel
// Carries the mapped point and the off-array flag.
// ---------------------------------------------------------------------------
`default_nettype none
interface gdbm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic               off_array;

  modport source (output valid, out_x, out_y, off_array, input ready);
  modport sink (input valid, out_x, out_y, off_array, output ready);
endinterface
`default_nettype wire

FILE: sv/gdbm_cfg_if.sv
// ---------------------------------------------------------------------------
// gdbm_cfg_if: configuration write channel
// Carries a register index and the data to write.
// ---------------------------------------------------------------------------
`default_nettype none
interface gdbm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/gdbm_ram.sv
// ---------------------------------------------------------------------------
// gdbm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module gdbm_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: sv/gdbm_mul.sv
// ---------------------------------------------------------------------------
// gdbm_mul: multi-cycle Q48.16 multiplier
// Forms a 64x64 product from four 32x32 partial products, floors it by
// 16 bits and saturates to plus or minus 2^60.
// ---------------------------------------------------------------------------
`default_nettype none
module gdbm_mul (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire gdbm_pkg::gdbm_mul_req_t req_i,
  output gdbm_pkg::gdbm_mul_rsp_t      rsp_o
);
  logic [63:0]  am_q, bm_q;
  logic         neg_q;
  logic [127:0] acc_q;
  logic [1:0]   cnt_q;
  logic         busy_q, fin_q, done_q;
  logic signed [61:0] res_q;

  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [1:0]   sh;
  logic signed [128:0] pval, fl;

  assign ah   = cnt_q[1] ? am_q[63:32] : am_q[31:0];
  assign bh   = cnt_q[0] ? bm_q[63:32] : bm_q[31:0];
  assign pp   = 64'(ah) * 64'(bh);
  assign sh   = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
  assign pval = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
  assign fl   = pval >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= fin_q;
      fin_q  <= busy_q && (cnt_q == 2'd3);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      am_q  <= req_i.a[63] ? 64'(-req_i.a) : 64'(req_i.a);
      bm_q  <= req_i.b[63] ? 64'(-req_i.b) : 64'(req_i.b);
      neg_q <= req_i.a[63] ^ req_i.b[63];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + (128'(pp) << {sh, 5'b0});
    end
    if (fin_q) begin
      if (fl > (129'sd1 <<< 60)) begin
        res_q <= 62'sd1 <<< 60;
      end else if (fl < -(129'sd1 <<< 60)) begin
        res_q <= -(62'sd1 <<< 60);
      end else begin
        res_q <= 62'(fl);
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> ##6 done_q) else $error("multiplier latency slip");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q && !fin_q) else $error("multiplier restarted busy");
endmodule
`default_nettype wire

FILE: sv/grid_distortion_bilinear_map.sv
// ---------------------------------------------------------------------------
// grid_distortion_bilinear_map: grid distortion map, bilinear interpolation
// Top level: configuration registers, offset memories and the sequencer.
// ---------------------------------------------------------------------------
// A load transaction writes one entry of both offset grids. An apply
// transaction maps its point through the affine transform, finds the grid
// cell, reads the four cell corners from each offset memory and
// interpolates both offsets, using eleven passes through the shared
// multiplier and four reads through the single read port of each offset
// memory. One item is worked on at a time; the result sits in an output
// register so the next item can start while it waits to be taken. The
// offset memories have no reset: reading an entry that was never loaded
// gives undefined offsets.
// Configuration may be written only while no apply is in flight.
// ---------------------------------------------------------------------------
`default_nettype none
module grid_distortion_bilinear_map #(
  parameter int MAX_COLS      = 64,
  parameter int MAX_GRID_ROWS = 64
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  gdbm_in_if.sink    in_i,
  gdbm_out_if.source out_o,
  gdbm_cfg_if.sink   cfg_i
);
  localparam int Depth = MAX_COLS * MAX_GRID_ROWS;
  localparam int AW    = $clog2(Depth);
  localparam int IW    = $clog2(MAX_COLS);
  localparam int JW    = $clog2(MAX_GRID_ROWS);

  typedef struct packed {
    logic        flag;
    logic [31:0] idx;
  } cell_t;

  // Configuration registers.
  logic signed [31:0] coef_q [6];
  logic [6:0]         gw_q, gh_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= 32'sd65536;
      coef_q[1] <= '0;
      coef_q[2] <= '0;
      coef_q[3] <= '0;
      coef_q[4] <= 32'sd65536;
      coef_q[5] <= '0;
      gw_q      <= 7'd64;
      gh_q      <= 7'd64;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        gdbm_pkg::CFG_GRID_W: gw_q <= cfg_i.data[6:0];
        gdbm_pkg::CFG_GRID_H: gh_q <= cfg_i.data[6:0];
        default:              coef_q[cfg_i.index] <= $signed(cfg_i.data);
      endcase
    end
  end

  // Grid size in use, clamped to 2..MAX.
  logic [31:0] w_use, h_use;
  always_comb begin
    w_use = 32'(gw_q);
    if (w_use < 32'd2) w_use = 32'd2;
    if (w_use > 32'(MAX_COLS)) w_use = 32'(MAX_COLS);
    h_use = 32'(gh_q);
    if (h_use < 32'd2) h_use = 32'd2;
    if (h_use > 32'(MAX_GRID_ROWS)) h_use = 32'(MAX_GRID_ROWS);
  end

  // Truncate toward zero, then clamp to 0..size-2.
  function automatic cell_t cell_fn(input logic signed [63:0] pix,
                                    input logic [31:0] size);
    cell_t       c;
    logic [63:0] k;
    c.flag = 1'b0;
    k      = pix[63] ? 64'd0 : 64'(pix >>> 16);
    c.idx  = 32'(k);
    if (pix <= -64'sd65536) begin
      c.idx  = 32'd0;
      c.flag = 1'b1;
    end else if (k >= 64'(size - 32'd1)) begin
      c.idx  = size - 32'd2;
      c.flag = 1'b1;
    end
    return c;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return 32'(v);
  endfunction

  gdbm_pkg::gdbm_state_e state_q, state_d;
  logic [3:0]         op_q;
  logic signed [31:0] x_q, y_q;
  logic signed [61:0] prod_q [gdbm_pkg::NUM_OPS];
  logic signed [63:0] xpix_q, ypix_q, xh_q, yh_q;
  logic [IW-1:0]      i_q;
  logic [JW-1:0]      j_q;
  logic               flag_q;
  logic [1:0]         rd_cnt_q;
  logic               cap_vld_q;
  logic [1:0]         cap_idx_q;
  logic signed [31:0] ax_q [4];
  logic signed [31:0] ay_q [4];
  logic signed [63:0] dx01_q, dx10_q, cx_q, dy01_q, dy10_q, cy_q;
  logic signed [63:0] dsx_q, dsy_q;
  logic               out_valid_q;
  logic signed [31:0] out_x_q, out_y_q;
  logic               out_flag_q;

  logic in_acc, ram_we, out_free;
  logic [AW-1:0] waddr, rd_addr;
  logic [31:0]   rdata_x, rdata_y;
  gdbm_pkg::gdbm_mul_req_t mul_req;
  gdbm_pkg::gdbm_mul_rsp_t mul_rsp;
  cell_t cx_cell, cy_cell;

  assign in_i.ready = (state_q == gdbm_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Loads go straight into both memories; out-of-range entries are dropped.
  assign ram_we = in_acc && (in_i.mode == gdbm_pkg::MODE_LOAD)
                  && (32'(in_i.grid_col) < 32'(MAX_COLS))
                  && (32'(in_i.grid_row) < 32'(MAX_GRID_ROWS));
  assign waddr  = AW'(32'(in_i.grid_row) * 32'(MAX_COLS) + 32'(in_i.grid_col));

  // Corner k reads column i + k[0] and row j + k[1].
  assign rd_addr = AW'((32'(j_q) + 32'(rd_cnt_q[1])) * 32'(MAX_COLS)
                       + 32'(i_q) + 32'(rd_cnt_q[0]));

  gdbm_ram #(.Width(32), .Depth(Depth)) u_ram_x (
    .clk_i, .we_i(ram_we), .waddr_i(waddr), .wdata_i(in_i.load_offset_x),
    .raddr_i(rd_addr), .rdata_o(rdata_x)
  );
  gdbm_ram #(.Width(32), .Depth(Depth)) u_ram_y (
    .clk_i, .we_i(ram_we), .waddr_i(waddr), .wdata_i(in_i.load_offset_y),
    .raddr_i(rd_addr), .rdata_o(rdata_y)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_req.start = (state_q == gdbm_pkg::ST_MISS);
    mul_req.a     = '0;
    mul_req.b     = '0;
    case (op_q)
      gdbm_pkg::OP_XX:   begin mul_req.a = 64'(coef_q[0]); mul_req.b = 64'(x_q); end
      gdbm_pkg::OP_XY:   begin mul_req.a = 64'(coef_q[1]); mul_req.b = 64'(y_q); end
      gdbm_pkg::OP_YX:   begin mul_req.a = 64'(coef_q[3]); mul_req.b = 64'(x_q); end
      gdbm_pkg::OP_YY:   begin mul_req.a = 64'(coef_q[4]); mul_req.b = 64'(y_q); end
      gdbm_pkg::OP_XHYH: begin mul_req.a = xh_q; mul_req.b = yh_q; end
      gdbm_pkg::OP_X01:  begin mul_req.a = xh_q; mul_req.b = dx01_q; end
      gdbm_pkg::OP_X10:  begin mul_req.a = yh_q; mul_req.b = dx10_q; end
      gdbm_pkg::OP_XC:   begin mul_req.a = 64'(prod_q[4]); mul_req.b = cx_q; end
      gdbm_pkg::OP_Y01:  begin mul_req.a = xh_q; mul_req.b = dy01_q; end
      gdbm_pkg::OP_Y10:  begin mul_req.a = yh_q; mul_req.b = dy10_q; end
      gdbm_pkg::OP_YC:   begin mul_req.a = 64'(prod_q[4]); mul_req.b = cy_q; end
      default:           begin mul_req.a = '0; mul_req.b = '0; end
    endcase
  end

  gdbm_mul u_mul (.clk_i, .rst_ni, .req_i(mul_req), .rsp_o(mul_rsp));

  assign cx_cell = cell_fn(xpix_q, w_use);
  assign cy_cell = cell_fn(ypix_q, h_use);

  always_comb begin
    state_d = state_q;
    case (state_q)
      gdbm_pkg::ST_IDLE:
        if (in_acc && in_i.mode == gdbm_pkg::MODE_APPLY) state_d = gdbm_pkg::ST_MISS;
      gdbm_pkg::ST_MISS: state_d = gdbm_pkg::ST_MWAIT;
      gdbm_pkg::ST_MWAIT: begin
        if (mul_rsp.done) begin
          if (op_q == gdbm_pkg::OP_YY) state_d = gdbm_pkg::ST_PIX;
          else if (op_q == gdbm_pkg::OP_YC) state_d = gdbm_pkg::ST_SUM;
          else state_d = gdbm_pkg::ST_MISS;
        end
      end
      gdbm_pkg::ST_PIX:  state_d = gdbm_pkg::ST_IDX;
      gdbm_pkg::ST_IDX:  state_d = gdbm_pkg::ST_RD;
      gdbm_pkg::ST_RD:   if (rd_cnt_q == 2'd3) state_d = gdbm_pkg::ST_RDL;
      gdbm_pkg::ST_RDL:  state_d = gdbm_pkg::ST_DIFF;
      gdbm_pkg::ST_DIFF: state_d = gdbm_pkg::ST_MISS;
      gdbm_pkg::ST_SUM:  state_d = gdbm_pkg::ST_FIN;
      gdbm_pkg::ST_FIN:  if (out_free) state_d = gdbm_pkg::ST_IDLE;
      default:           state_d = gdbm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gdbm_pkg::ST_IDLE;
      op_q        <= gdbm_pkg::OP_XX;
      rd_cnt_q    <= 2'd0;
      cap_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cap_vld_q <= (state_q == gdbm_pkg::ST_RD);
      if (state_q == gdbm_pkg::ST_IDLE) op_q <= gdbm_pkg::OP_XX;
      else if (state_q == gdbm_pkg::ST_MWAIT && mul_rsp.done) op_q <= op_q + 4'd1;
      if (state_q == gdbm_pkg::ST_RD) rd_cnt_q <= rd_cnt_q + 2'd1;
      else rd_cnt_q <= 2'd0;
      if (state_q == gdbm_pkg::ST_FIN && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cap_idx_q <= rd_cnt_q;
    if (in_acc) begin
      x_q <= in_i.coord_x;
      y_q <= in_i.coord_y;
    end
    if (state_q == gdbm_pkg::ST_MWAIT && mul_rsp.done) begin
      prod_q[op_q] <= mul_rsp.result;
    end
    if (state_q == gdbm_pkg::ST_PIX) begin
      xpix_q <= 64'(prod_q[0]) + 64'(prod_q[1]) + 64'(coef_q[2]);
      ypix_q <= 64'(prod_q[2]) + 64'(prod_q[3]) + 64'(coef_q[5]);
    end
    if (state_q == gdbm_pkg::ST_IDX) begin
      i_q    <= IW'(cx_cell.idx);
      j_q    <= JW'(cy_cell.idx);
      flag_q <= cx_cell.flag | cy_cell.flag;
      xh_q   <= xpix_q - $signed(64'({cx_cell.idx, 16'b0}));
      yh_q   <= ypix_q - $signed(64'({cy_cell.idx, 16'b0}));
    end
    if (cap_vld_q) begin
      ax_q[cap_idx_q] <= $signed(rdata_x);
      ay_q[cap_idx_q] <= $signed(rdata_y);
    end
    if (state_q == gdbm_pkg::ST_DIFF) begin
      dx01_q <= 64'(ax_q[1]) - 64'(ax_q[0]);
      dx10_q <= 64'(ax_q[2]) - 64'(ax_q[0]);
      cx_q   <= 64'(ax_q[3]) - 64'(ax_q[2]) - 64'(ax_q[1]) + 64'(ax_q[0]);
      dy01_q <= 64'(ay_q[1]) - 64'(ay_q[0]);
      dy10_q <= 64'(ay_q[2]) - 64'(ay_q[0]);
      cy_q   <= 64'(ay_q[3]) - 64'(ay_q[2]) - 64'(ay_q[1]) + 64'(ay_q[0]);
    end
    if (state_q == gdbm_pkg::ST_SUM) begin
      dsx_q <= 64'(ax_q[0]) + 64'(prod_q[5]) + 64'(prod_q[6]) + 64'(prod_q[7]);
      dsy_q <= 64'(ay_q[0]) + 64'(prod_q[8]) + 64'(prod_q[9]) + 64'(prod_q[10]);
    end
    if (state_q == gdbm_pkg::ST_FIN && out_free) begin
      out_x_q    <= sat32(64'(x_q) + dsx_q);
      out_y_q    <= sat32(64'(y_q) + dsy_q);
      out_flag_q <= flag_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_x     = out_x_q;
  assign out_o.out_y     = out_y_q;
  assign out_o.off_array = out_flag_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> state_q == gdbm_pkg::ST_MWAIT)
    else $error("multiplier result arrived outside wait state");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gdbm_pkg::ST_FIN && out_valid_q && !out_o.ready)
    |=> state_q == gdbm_pkg::ST_FIN)
    else $error("pending result overwritten");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == gdbm_pkg::ST_IDLE && !cap_vld_q)
    else $error("grid load during apply");
endmodule
`default_nettype wire
